@@ rtl/core/iacc_pkg.sv @@
// Shared constants and types for the integer accumulator ALU.
package iacc_pkg;

    localparam int DW    = 32;
    localparam int CNT_W = $clog2(DW);

    localparam int OP_W  = 3;
    localparam int ST_W  = 2;

    // Input tdata: opcode, left operand, right operand, padded to bytes.
    localparam int S_DATA_BITS = OP_W + 2 * DW;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_W    = ((DW + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_REM = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_OP   = 2'd1;
    localparam logic [ST_W-1:0] ST_DIV_ZERO = 2'd2;

    // Engine to top: finished result
    typedef struct packed {
        logic            done;
        logic [DW-1:0]   value;
        logic [ST_W-1:0] status;
    } t_eng_res;

endpackage

@@ rtl/core/iacc_serial.sv @@
// Bit-serial arithmetic engine: serial add/sub, shift-add multiply, restoring divide.
module iacc_serial (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [iacc_pkg::OP_W-1:0]     i_op,
    input  logic [iacc_pkg::DW-1:0]       i_a,
    input  logic [iacc_pkg::DW-1:0]       i_b,
    input  logic                          i_take,
    output logic                          o_idle,
    output iacc_pkg::t_eng_res            o_res
);

    localparam int DW    = iacc_pkg::DW;
    localparam int CNT_W = iacc_pkg::CNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_SIGN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [CNT_W-1:0]           r_cnt,   n_cnt;
    logic [iacc_pkg::OP_W-1:0]  r_op,    n_op;
    logic [iacc_pkg::ST_W-1:0]  r_st,    n_st;
    logic [DW-1:0]              r_x,     n_x;
    logic [DW-1:0]              r_y,     n_y;
    logic [DW-1:0]              r_z,     n_z;
    logic                       r_c,     n_c;
    logic                       r_neg_q, n_neg_q;
    logic                       r_neg_r, n_neg_r;

    logic          a_neg, b_neg, sub, sum_bit;
    logic [DW-1:0] a_mag, b_mag;
    logic [DW:0]   div_sh, div_tr;

    always_comb begin
        a_neg   = i_a[DW-1];
        b_neg   = i_b[DW-1];
        a_mag   = a_neg ? ('0 - i_a) : i_a;
        b_mag   = b_neg ? ('0 - i_b) : i_b;
        sub     = (i_op == iacc_pkg::OP_SUB);
        sum_bit = r_x[0] ^ r_y[0] ^ r_c;
        div_sh  = {r_z, r_x[DW-1]};
        div_tr  = div_sh - {1'b0, r_y};
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_st    = r_st;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_c     = r_c;
        n_neg_q = r_neg_q;
        n_neg_r = r_neg_r;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_op;
                    n_st    = iacc_pkg::ST_OK;
                    n_cnt   = CNT_W'(DW - 1);
                    n_z     = '0;
                    n_c     = sub;
                    n_neg_q = a_neg ^ b_neg;
                    n_neg_r = a_neg;
                    n_x     = i_a;
                    n_y     = sub ? ~i_b : i_b;
                    n_state = S_RUN;
                    unique case (i_op) inside
                        iacc_pkg::OP_ADD, iacc_pkg::OP_SUB, iacc_pkg::OP_MUL: begin
                        end
                        iacc_pkg::OP_DIV, iacc_pkg::OP_REM: begin
                            n_x = a_mag;
                            n_y = b_mag;
                            if (i_b == '0) begin
                                n_st    = iacc_pkg::ST_DIV_ZERO;
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_st    = iacc_pkg::ST_BAD_OP;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                case (r_op) inside
                    iacc_pkg::OP_ADD, iacc_pkg::OP_SUB: begin
                        // LSB first, sum bits enter at the top of r_z
                        n_z = {sum_bit, r_z[DW-1:1]};
                        n_c = (r_x[0] & r_y[0]) | (r_c & (r_x[0] ^ r_y[0]));
                        n_x = r_x >> 1;
                        n_y = r_y >> 1;
                    end
                    iacc_pkg::OP_MUL: begin
                        if (r_y[0]) begin
                            n_z = r_z + r_x;
                        end
                        n_x = r_x << 1;
                        n_y = r_y >> 1;
                    end
                    default: begin
                        // restoring step: dividend shifts out of r_x, quotient shifts in
                        if (!div_tr[DW]) begin
                            n_z = div_tr[DW-1:0];
                        end else begin
                            n_z = div_sh[DW-1:0];
                        end
                        n_x = {r_x[DW-2:0], ~div_tr[DW]};
                    end
                endcase
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                if (r_op == iacc_pkg::OP_DIV) begin
                    n_z = r_neg_q ? ('0 - r_x) : r_x;
                end else if (r_op == iacc_pkg::OP_REM) begin
                    n_z = r_neg_r ? ('0 - r_z) : r_z;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt   <= n_cnt;
        r_op    <= n_op;
        r_st    <= n_st;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_c     <= n_c;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_res.done   = (r_state == S_DONE);
    assign o_res.value  = r_z;
    assign o_res.status = r_st;

endmodule

@@ rtl/core/integer_accumulator_alu.sv @@
// Top level: stream ports, accumulator and output register around the serial engine.
//
//  channel | dir | tdata (low bit first)                          | tuser
//  s       | in  | opcode[2:0], left_operand[34:3],                | start_chain
//          |     | right_operand[66:35], zero pad to 72 bits      |
//  m       | out | value[31:0]                                    | status[1:0]
//
// Add, subtract, multiply, divide and remainder pass from transfer to result valid
// through DW bit steps in the serial engine, one sign fix and one output register.
// Invalid opcodes and zero divisors skip the bit steps and the sign fix.
// One item is in the engine at a time; the next is taken once the previous result
// has moved into the output register. Reset clears the accumulator.
// A stalled output holds its transfer and back-pressures the engine.
module integer_accumulator_alu (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [iacc_pkg::S_DATA_W-1:0]   i_s_tdata,  // opcode, left_operand, right_operand
    input  logic                            i_s_tuser,  // start_chain
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [iacc_pkg::M_DATA_W-1:0]   o_m_tdata,  // value
    output logic [iacc_pkg::ST_W-1:0]       o_m_tuser   // status
);

    localparam int DW   = iacc_pkg::DW;
    localparam int OPW  = iacc_pkg::OP_W;
    localparam int MDW  = iacc_pkg::M_DATA_W;

    logic [DW-1:0]             r_acc;
    logic                      r_out_valid;
    logic [DW-1:0]             r_out_value;
    logic [iacc_pkg::ST_W-1:0] r_out_status;

    logic                 eng_idle;
    logic                 s_xfer;
    logic                 take;
    logic [OPW-1:0]       in_op;
    logic [DW-1:0]        in_left, in_right, op_a;
    iacc_pkg::t_eng_res   eng_res;

    assign in_op    = i_s_tdata[OPW-1:0];
    assign in_left  = i_s_tdata[OPW+DW-1:OPW];
    assign in_right = i_s_tdata[OPW+2*DW-1:OPW+DW];
    assign op_a     = i_s_tuser ? in_left : r_acc;

    assign o_s_tready = eng_idle;
    assign s_xfer     = i_s_tvalid && eng_idle;
    assign take       = eng_res.done && (!r_out_valid || i_m_tready);

    iacc_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_xfer),
        .i_op    (in_op),
        .i_a     (op_a),
        .i_b     (in_right),
        .i_take  (take),
        .o_idle  (eng_idle),
        .o_res   (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
                if (eng_res.status == iacc_pkg::ST_OK) begin
                    r_acc <= eng_res.value;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (take) begin
            r_out_value  <= (eng_res.status == iacc_pkg::ST_OK) ? eng_res.value : r_acc;
            r_out_status <= eng_res.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = MDW'(r_out_value);
    assign o_m_tuser  = r_out_status;

endmodule
